@@ rtl/core/at_command_line_parser_top_assert.svh @@
// Assertion helpers for the AT line parser; clk and arst_n must be in scope.
`ifndef AT_COMMAND_LINE_PARSER_TOP_ASSERT_SVH
`define AT_COMMAND_LINE_PARSER_TOP_ASSERT_SVH

`define AT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define AT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/at_clp_pkg.sv @@
package at_clp_pkg;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] rx_byte;
		logic [4:0] entry_index;
		logic [3:0] name_position;
		logic [4:0] name_length;
		logic [3:0] handler_mask;
		logic [3:0] min_arguments;
		logic [3:0] max_arguments;
		logic       format_valid;
	} in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [4:0] command_index;
		logic [1:0] form;
		logic [1:0] error_code;
		logic [7:0] args_offset;
		logic [8:0] line_length;
		logic       last;
	} out_t;

	typedef struct packed {
		logic [7:0] a0;
		logic [7:0] a1;
		logic [7:0] a2;
		logic [3:0] mask;
		logic [3:0] min_args;
		logic [3:0] max_args;
		logic       fmt_ok;
	} cls_in_t;

	typedef struct packed {
		logic [1:0] form;
		logic [1:0] err;
	} cls_res_t;

	localparam logic [1:0] MODE_BYTE = 2'd0;
	localparam logic [1:0] MODE_NAME = 2'd1;
	localparam logic [1:0] MODE_ATTR = 2'd2;

	localparam logic [1:0] KIND_ECHO     = 2'd0;
	localparam logic [1:0] KIND_DISPATCH = 2'd1;
	localparam logic [1:0] KIND_ERROR    = 2'd2;

	localparam logic [1:0] FORM_TEST  = 2'd0;
	localparam logic [1:0] FORM_QUERY = 2'd1;
	localparam logic [1:0] FORM_SETUP = 2'd2;
	localparam logic [1:0] FORM_EXEC  = 2'd3;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_MATCH = 2'd1;
	localparam logic [1:0] ERR_ARGS  = 2'd2;
	localparam logic [1:0] ERR_FORM  = 2'd3;

	localparam logic [2:0] CFG_ECHO   = 3'd0;
	localparam logic [2:0] CFG_MARK1  = 3'd1;
	localparam logic [2:0] CFG_MARK2  = 3'd2;
	localparam logic [2:0] CFG_MARKLEN = 3'd3;
	localparam logic [2:0] CFG_COUNT  = 3'd4;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic ends_name(input logic [7:0] c);
		return (c == CH_QUEST) || (c == CH_EQ) || (c == CH_CR) || is_digit(c);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return ((c >= CH_UA) && (c <= CH_UZ)) ? (c + 8'd32) : c;
	endfunction

endpackage

@@ rtl/core/at_clp_ram.sv @@
module at_clp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/at_clp_classify.sv @@
module at_clp_classify import at_clp_pkg::*; #(
	parameter int COUNT_W = 9
) (
	input  cls_in_t            cin,
	input  logic [COUNT_W-1:0] commas,
	output cls_res_t           res
);

	logic [COUNT_W:0] args;
	logic             form_ok;
	logic [1:0]       form;

	assign args = {1'b0, commas} + 1'b1;

	always_comb begin
		form_ok = 1'b1;
		form = FORM_TEST;
		if (cin.a0 == CH_EQ && cin.a1 == CH_QUEST && cin.a2 == CH_CR) begin
			form = FORM_TEST;
		end else if (cin.a0 == CH_QUEST && cin.a1 == CH_CR) begin
			form = FORM_QUERY;
		end else if (cin.a0 == CH_EQ || (is_digit(cin.a0) && cin.a1 == CH_CR)) begin
			form = FORM_SETUP;
		end else if (cin.a0 == CH_CR) begin
			form = FORM_EXEC;
		end else begin
			form_ok = 1'b0;
		end
	end

	always_comb begin
		res.form = form;
		res.err = ERR_NONE;
		if (!form_ok) begin
			res.form = FORM_TEST;
			res.err = ERR_FORM;
		end else if (!cin.mask[form]) begin
			res.err = ERR_MATCH;
		end else if (form == FORM_SETUP && (!cin.fmt_ok
				|| args < (COUNT_W+1)'(cin.min_args)
				|| args > (COUNT_W+1)'(cin.max_args))) begin
			res.err = ERR_ARGS;
		end
	end

endmodule

@@ rtl/core/at_command_line_parser_top.sv @@
// AT command line parser.
// in_valid/in_stall carry one in_t request: a received byte (mode 0) or a
// command table load (modes 1 and 2). in_stall is high while a request is at
// work; a table load never raises it, a stored byte is checked for a line end
// and echoed, a backspace on a non-empty line drops a byte and is echoed. At
// a line end the line is scanned byte by byte, then each table entry is read
// and a length match compares the name character by character, then one
// dispatch or error result follows. The scan reads the line memory and the
// name compare the name table. out_valid/out_stall carry out_t results; last
// marks the final result of a request. A stalled result holds in the output
// register and the sequencer waits on it. cfg_we writes register cfg_index
// with cfg_data; the user must do so only when idle, the block does not
// enforce it. Reset empties the line, clears the stop flag and loads the
// register defaults; line and table memories are not cleared and need no
// sweep. ESC stops byte handling until reset; table loads still work.
`include "at_command_line_parser_top_assert.svh"

module at_command_line_parser_top import at_clp_pkg::*; #(
	parameter int LINE_CAPACITY = 256,
	parameter int NAME_MAX      = 16,
	parameter int TABLE_ENTRIES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       out_data,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int LAW  = $clog2(LINE_CAPACITY);
	localparam int FW   = $clog2(LINE_CAPACITY + 1);
	localparam int NW   = $clog2(NAME_MAX);
	localparam int LW   = $clog2(NAME_MAX + 1);
	localparam int EW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int TAW  = (TABLE_ENTRIES * NAME_MAX > 1) ? $clog2(TABLE_ENTRIES * NAME_MAX) : 1;
	localparam int CW0  = $clog2(TABLE_ENTRIES + 1);
	localparam int CNTW = (CW0 > 6) ? CW0 : 6;
	localparam int ATW  = LW + 13;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_CHK      = 4'd1;
	localparam logic [3:0] ST_ECHO     = 4'd2;
	localparam logic [3:0] ST_SCAN_RD  = 4'd3;
	localparam logic [3:0] ST_SCAN_CHK = 4'd4;
	localparam logic [3:0] ST_M_RD     = 4'd5;
	localparam logic [3:0] ST_M_LEN    = 4'd6;
	localparam logic [3:0] ST_C_RD     = 4'd7;
	localparam logic [3:0] ST_C_CHK    = 4'd8;
	localparam logic [3:0] ST_CLASS    = 4'd9;
	localparam logic [3:0] ST_EMIT     = 4'd10;

	localparam logic [1:0] ECHO_NONE = 2'd0;
	localparam logic [1:0] ECHO_BYTE = 2'd1;
	localparam logic [1:0] ECHO_CRLF = 2'd2;
	localparam logic [1:0] ECHO_BSB  = 2'd3;

	logic [3:0]      state_q;
	logic            echo_en_q;
	logic [7:0]      mark1_q, mark2_q;
	logic [1:0]      mark_len_q;
	logic [5:0]      cmd_count_q;
	logic [FW-1:0]   fill_q, before_q, len_q, i_q, nl_q, commas_q;
	logic [7:0]      prev_q, b_q, a0_q, a1_q, a2_q;
	logic            stopped_q, hit_q, found_q;
	logic [1:0]      echo_sel_q, echo_pos_q;
	logic [CNTW-1:0] e_q, cnt;
	logic [TAW-1:0]  base_q;
	logic [LW-1:0]   j_q;
	logic [ATW-1:0]  attr_q;
	out_t            res_q, out_q, emit_data;
	logic            out_valid_q;
	logic [7:0]      name_q [NAME_MAX];

	logic            accept, can_emit, emit_ld, is_bs, hit;
	logic [1:0]      echo_cnt;
	logic [7:0]      echo_byte, c;
	logic [FW-1:0]   rel;
	logic            ls_we, nt_we, at_we;
	logic [LAW-1:0]  ls_raddr;
	logic [7:0]      ls_rdata, nt_rdata;
	logic [ATW-1:0]  at_rdata;
	logic [LW-1:0]   wr_len;
	cls_in_t         cls_in;
	cls_res_t        cls_res;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign can_emit  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign is_bs     = echo_en_q && (in_data.rx_byte == CH_BS || in_data.rx_byte == CH_DEL);
	assign cnt = (CNTW'(cmd_count_q) >= CNTW'(TABLE_ENTRIES)) ? CNTW'(TABLE_ENTRIES)
		: CNTW'(cmd_count_q);
	assign c   = ls_rdata;
	assign rel = i_q - nl_q;

	assign ls_we = accept && in_data.mode == MODE_BYTE && !stopped_q
		&& in_data.rx_byte != CH_ESC && !is_bs && fill_q < FW'(LINE_CAPACITY);
	assign ls_raddr = (state_q == ST_IDLE) ? LAW'(fill_q - 1'b1) : LAW'(i_q);
	assign nt_we = accept && in_data.mode == MODE_NAME
		&& 32'(in_data.entry_index) < TABLE_ENTRIES && 32'(in_data.name_position) < NAME_MAX;
	assign at_we = accept && in_data.mode == MODE_ATTR
		&& 32'(in_data.entry_index) < TABLE_ENTRIES;
	assign wr_len = (32'(in_data.name_length) > NAME_MAX) ? LW'(NAME_MAX)
		: LW'(in_data.name_length);

	at_clp_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_line (
		.clk(clk), .we(ls_we), .waddr(LAW'(fill_q)), .wdata(in_data.rx_byte),
		.raddr(ls_raddr), .rdata(ls_rdata)
	);

	at_clp_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES * NAME_MAX)) u_names (
		.clk(clk), .we(nt_we),
		.waddr(TAW'(32'(in_data.entry_index) * NAME_MAX + 32'(in_data.name_position))),
		.wdata(in_data.rx_byte), .raddr(TAW'(base_q + TAW'(j_q))), .rdata(nt_rdata)
	);

	at_clp_ram #(.WIDTH(ATW), .DEPTH(TABLE_ENTRIES)) u_attr (
		.clk(clk), .we(at_we), .waddr(EW'(in_data.entry_index)),
		.wdata({wr_len, in_data.handler_mask, in_data.min_arguments,
			in_data.max_arguments, in_data.format_valid}),
		.raddr(EW'(e_q)), .rdata(at_rdata)
	);

	assign cls_in = '{a0: a0_q, a1: a1_q, a2: a2_q, mask: attr_q[12:9],
		min_args: attr_q[8:5], max_args: attr_q[4:1], fmt_ok: attr_q[0]};

	at_clp_classify #(.COUNT_W(FW)) u_cls (
		.cin(cls_in), .commas(commas_q), .res(cls_res)
	);

	// second mark byte completes the line only if the stored byte before it is the first
	assign hit = (mark_len_q == 2'd2)
		? (b_q == mark2_q && before_q != '0 && ls_rdata == mark1_q)
		: (b_q == mark1_q);

	always_comb begin
		case (echo_sel_q)
			ECHO_BYTE: echo_cnt = 2'd1;
			ECHO_CRLF: echo_cnt = 2'd2;
			ECHO_BSB:  echo_cnt = 2'd3;
			default:   echo_cnt = 2'd0;
		endcase
		case (echo_sel_q)
			ECHO_BYTE: echo_byte = b_q;
			ECHO_CRLF: echo_byte = (echo_pos_q == 2'd0) ? CH_CR : CH_LF;
			ECHO_BSB:  echo_byte = (echo_pos_q == 2'd1) ? CH_SP : CH_BS;
			default:   echo_byte = 8'd0;
		endcase
	end

	assign emit_ld = can_emit && ((state_q == ST_ECHO && echo_pos_q < echo_cnt)
		|| state_q == ST_EMIT);

	always_comb begin
		emit_data = '0;
		if (state_q == ST_EMIT) begin
			emit_data = res_q;
			emit_data.last = 1'b1;
		end else begin
			emit_data.kind = KIND_ECHO;
			emit_data.out_byte = echo_byte;
			emit_data.last = (echo_pos_q == echo_cnt - 2'd1) && !hit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ld) begin
			out_q <= emit_data;
		end
		if (state_q == ST_SCAN_CHK && !found_q && !ends_name(c) && 32'(i_q) < NAME_MAX) begin
			name_q[NW'(i_q)] <= to_lower(c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_en_q <= 1'b1;
			mark1_q <= CH_CR;
			mark2_q <= CH_LF;
			mark_len_q <= 2'd2;
			cmd_count_q <= 6'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ECHO:    echo_en_q <= cfg_data[0];
				CFG_MARK1:   mark1_q <= cfg_data;
				CFG_MARK2:   mark2_q <= cfg_data;
				CFG_MARKLEN: mark_len_q <= cfg_data[1:0];
				CFG_COUNT:   cmd_count_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			prev_q <= 8'd0;
			stopped_q <= 1'b0;
			before_q <= '0;
			len_q <= '0;
			i_q <= '0;
			nl_q <= '0;
			commas_q <= '0;
			b_q <= 8'd0;
			a0_q <= 8'd0;
			a1_q <= 8'd0;
			a2_q <= 8'd0;
			hit_q <= 1'b0;
			found_q <= 1'b0;
			echo_sel_q <= ECHO_NONE;
			echo_pos_q <= 2'd0;
			e_q <= '0;
			base_q <= '0;
			j_q <= '0;
			attr_q <= '0;
			res_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					echo_pos_q <= 2'd0;
					if (accept && in_data.mode == MODE_BYTE && !stopped_q) begin
						b_q <= in_data.rx_byte;
						if (in_data.rx_byte == CH_ESC) begin
							stopped_q <= 1'b1;
						end else if (is_bs) begin
							// editing: drop the last byte, nothing stored
							if (fill_q != '0) begin
								fill_q <= fill_q - 1'b1;
								echo_sel_q <= ECHO_BSB;
								hit_q <= 1'b0;
								state_q <= ST_ECHO;
							end
						end else begin
							if (!echo_en_q) begin
								echo_sel_q <= ECHO_NONE;
							end else if (in_data.rx_byte == CH_CR
									|| (in_data.rx_byte == CH_LF && prev_q != CH_CR)) begin
								echo_sel_q <= ECHO_CRLF;
							end else if (in_data.rx_byte == CH_LF) begin
								echo_sel_q <= ECHO_NONE;
							end else begin
								echo_sel_q <= ECHO_BYTE;
							end
							if (fill_q < FW'(LINE_CAPACITY)) begin
								fill_q <= fill_q + 1'b1;
							end
							before_q <= fill_q;
							prev_q <= in_data.rx_byte;
							state_q <= ST_CHK;
						end
					end
				end
				ST_CHK: begin
					hit_q <= hit;
					len_q <= fill_q;
					state_q <= ST_ECHO;
				end
				ST_ECHO: begin
					if (echo_pos_q < echo_cnt) begin
						if (can_emit) begin
							echo_pos_q <= echo_pos_q + 2'd1;
						end
					end else if (hit_q) begin
						i_q <= '0;
						found_q <= 1'b0;
						nl_q <= '0;
						commas_q <= '0;
						a0_q <= 8'd0;
						a1_q <= 8'd0;
						a2_q <= 8'd0;
						state_q <= ST_SCAN_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN_RD: begin
					if (i_q == len_q) begin
						res_q <= '{kind: KIND_ERROR, out_byte: 8'd0, command_index: 5'd0,
							form: FORM_TEST, error_code: ERR_MATCH,
							args_offset: (found_q ? 8'(nl_q) : 8'd0),
							line_length: 9'(len_q), last: 1'b0};
						if (found_q && 32'(nl_q) <= NAME_MAX) begin
							e_q <= '0;
							base_q <= '0;
							state_q <= ST_M_RD;
						end else begin
							state_q <= ST_EMIT;
						end
					end else begin
						state_q <= ST_SCAN_CHK;
					end
				end
				ST_SCAN_CHK: begin
					if (!found_q) begin
						if (ends_name(c)) begin
							found_q <= 1'b1;
							nl_q <= i_q;
							a0_q <= c;
						end
					end else begin
						if (rel == FW'(1)) begin
							a1_q <= c;
						end
						if (rel == FW'(2)) begin
							a2_q <= c;
						end
						if (c == CH_COMMA) begin
							commas_q <= commas_q + 1'b1;
						end
					end
					i_q <= i_q + 1'b1;
					state_q <= ST_SCAN_RD;
				end
				ST_M_RD: begin
					if (e_q == cnt) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_M_LEN;
					end
				end
				ST_M_LEN: begin
					if (at_rdata[ATW-1:13] == LW'(nl_q)) begin
						attr_q <= at_rdata;
						j_q <= '0;
						state_q <= ST_C_RD;
					end else begin
						e_q <= e_q + 1'b1;
						base_q <= base_q + TAW'(NAME_MAX);
						state_q <= ST_M_RD;
					end
				end
				ST_C_RD: begin
					if (j_q == LW'(nl_q)) begin
						state_q <= ST_CLASS;
					end else begin
						state_q <= ST_C_CHK;
					end
				end
				ST_C_CHK: begin
					if (to_lower(nt_rdata) == name_q[NW'(j_q)]) begin
						j_q <= j_q + 1'b1;
						state_q <= ST_C_RD;
					end else begin
						e_q <= e_q + 1'b1;
						base_q <= base_q + TAW'(NAME_MAX);
						state_q <= ST_M_RD;
					end
				end
				ST_CLASS: begin
					res_q.kind <= (cls_res.err == ERR_NONE) ? KIND_DISPATCH : KIND_ERROR;
					res_q.command_index <= 5'(e_q);
					res_q.form <= cls_res.form;
					res_q.error_code <= cls_res.err;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (can_emit) begin
						fill_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`AT_ASSERT_IMP(a_fill_cap, 1'b1, fill_q <= FW'(LINE_CAPACITY), "line fill past capacity")
	`AT_ASSERT_IMP(a_scan_bound, state_q == ST_SCAN_RD, i_q <= len_q, "scan ran past line end")
	`AT_ASSERT_NXT(a_line_clear, state_q == ST_EMIT && can_emit, fill_q == '0 && !in_stall,
		"line not cleared after result")

endmodule

@@ test/tb_at_command_line_parser_top.sv @@
import at_clp_pkg::*;

// Expected results of the AT line parser, worked out per accepted request.
class line_scoreboard;
	localparam int LINE_CAP = 256;
	localparam int NMAX = 16;
	localparam int TBL = 32;

	bit       echo_on;
	bit [7:0] mark_a, mark_b;
	bit [1:0] mark_len;
	bit [5:0] cmd_count;

	bit [7:0] line_buf[LINE_CAP];
	int       fill;
	bit [7:0] prev_byte;
	bit       halted;

	bit [7:0] ent_name[TBL][NMAX];
	int       ent_len[TBL];
	bit [3:0] ent_mask[TBL], ent_min[TBL], ent_max[TBL];
	bit       ent_fmt[TBL];

	out_t     expected[$];
	int       mismatches;
	int       checked;

	function new();
		echo_on = 1;
		mark_a = CH_CR;
		mark_b = CH_LF;
		mark_len = 2;
		cmd_count = 0;
		fill = 0;
		prev_byte = 0;
		halted = 0;
	endfunction

	function void write_reg(bit [2:0] idx, bit [7:0] v);
		case (idx)
			CFG_ECHO: echo_on = v[0];
			CFG_MARK1: mark_a = v;
			CFG_MARK2: mark_b = v;
			CFG_MARKLEN: mark_len = v[1:0];
			CFG_COUNT: cmd_count = v[5:0];
			default: ;
		endcase
	endfunction

	function void push(bit [1:0] k, bit [7:0] b, int idx, bit [1:0] form, bit [1:0] err,
			int off, int len);
		out_t o;
		o = '0;
		o.kind = k;
		o.out_byte = b;
		o.command_index = 5'(idx);
		o.form = form;
		o.error_code = err;
		o.args_offset = 8'(off);
		o.line_length = 9'(len);
		expected.push_back(o);
	endfunction

	function bit [7:0] fold(bit [7:0] c);
		return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
	endfunction

	function bit name_stop(bit [7:0] c);
		return c == CH_QUEST || c == CH_EQ || c == CH_CR || (c >= CH_0 && c <= CH_9);
	endfunction

	function bit [7:0] arg_at(int i, int len);
		return (i < len) ? line_buf[i] : 8'd0;
	endfunction

	function void judge_line(int len);
		int nl, hit, cnt, commas;
		bit found, same;
		bit [7:0] a0, a1, a2;
		bit [1:0] form;
		nl = 0;
		found = 0;
		hit = -1;
		for (int i = 0; i < len; i++)
			if (!found && name_stop(line_buf[i])) begin
				nl = i;
				found = 1;
			end
		if (!found) begin
			push(KIND_ERROR, 8'd0, 0, FORM_TEST, ERR_MATCH, 0, len);
			return;
		end
		cnt = (cmd_count < TBL) ? cmd_count : TBL;
		if (nl <= NMAX)
			for (int e = 0; e < cnt && hit < 0; e++) begin
				same = (ent_len[e] == nl);
				for (int i = 0; same && i < nl; i++)
					if (fold(ent_name[e][i]) != fold(line_buf[i]))
						same = 0;
				if (same)
					hit = e;
			end
		if (hit < 0) begin
			push(KIND_ERROR, 8'd0, 0, FORM_TEST, ERR_MATCH, nl, len);
			return;
		end
		a0 = arg_at(nl, len);
		a1 = arg_at(nl + 1, len);
		a2 = arg_at(nl + 2, len);
		if (a0 == CH_EQ && a1 == CH_QUEST && a2 == CH_CR)
			form = FORM_TEST;
		else if (a0 == CH_QUEST && a1 == CH_CR)
			form = FORM_QUERY;
		else if (a0 == CH_EQ || (a0 >= CH_0 && a0 <= CH_9 && a1 == CH_CR))
			form = FORM_SETUP;
		else if (a0 == CH_CR)
			form = FORM_EXEC;
		else begin
			push(KIND_ERROR, 8'd0, hit, FORM_TEST, ERR_FORM, nl, len);
			return;
		end
		if (!ent_mask[hit][form]) begin
			push(KIND_ERROR, 8'd0, hit, form, ERR_MATCH, nl, len);
			return;
		end
		if (form == FORM_SETUP) begin
			commas = 0;
			for (int i = nl; i < len; i++)
				if (line_buf[i] == CH_COMMA)
					commas++;
			if (!ent_fmt[hit] || commas + 1 < ent_min[hit] || commas + 1 > ent_max[hit]) begin
				push(KIND_ERROR, 8'd0, hit, form, ERR_ARGS, nl, len);
				return;
			end
		end
		push(KIND_DISPATCH, 8'd0, hit, form, ERR_NONE, nl, len);
	endfunction

	function void take_byte(bit [7:0] b);
		int slot;
		bit mark_hit;
		if (halted)
			return;
		if (b == CH_ESC) begin
			halted = 1;
			return;
		end
		if (echo_on) begin
			if (b == CH_CR || (b == CH_LF && prev_byte != CH_CR)) begin
				push(KIND_ECHO, CH_CR, 0, FORM_TEST, ERR_NONE, 0, 0);
				push(KIND_ECHO, CH_LF, 0, FORM_TEST, ERR_NONE, 0, 0);
			end else if (b == CH_LF) begin
				// LF right after CR is stored but not echoed
			end else if (b == CH_BS || b == CH_DEL) begin
				if (fill > 0) begin
					fill--;
					push(KIND_ECHO, CH_BS, 0, FORM_TEST, ERR_NONE, 0, 0);
					push(KIND_ECHO, CH_SP, 0, FORM_TEST, ERR_NONE, 0, 0);
					push(KIND_ECHO, CH_BS, 0, FORM_TEST, ERR_NONE, 0, 0);
				end
				return;
			end else
				push(KIND_ECHO, b, 0, FORM_TEST, ERR_NONE, 0, 0);
		end
		slot = fill;
		if (slot < LINE_CAP) begin
			line_buf[slot] = b;
			fill = slot + 1;
		end
		prev_byte = b;
		if (mark_len == 2)
			mark_hit = b == mark_b && slot > 0 && line_buf[slot - 1] == mark_a;
		else
			mark_hit = b == mark_a;
		if (mark_hit) begin
			judge_line(fill);
			fill = 0;
		end
	endfunction

	function void note_request(in_t r);
		int base;
		base = expected.size();
		case (r.mode)
			MODE_NAME: ent_name[r.entry_index][r.name_position] = r.rx_byte;
			MODE_ATTR: begin
				ent_len[r.entry_index] = (r.name_length > NMAX) ? NMAX : int'(r.name_length);
				ent_mask[r.entry_index] = r.handler_mask;
				ent_min[r.entry_index] = r.min_arguments;
				ent_max[r.entry_index] = r.max_arguments;
				ent_fmt[r.entry_index] = r.format_valid;
			end
			MODE_BYTE: take_byte(r.rx_byte);
			default: ;
		endcase
		if (expected.size() > base)
			expected[expected.size() - 1].last = 1;
	endfunction

	task report(string what, int got, int want);
		mismatches++;
		if (mismatches <= 60)
			$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
	endtask

	task check_result(out_t got);
		out_t want;
		if (expected.size() == 0) begin
			report("result with nothing pending, kind", got.kind, -1);
			return;
		end
		want = expected.pop_front();
		checked++;
		if (got.kind != want.kind) report("kind", got.kind, want.kind);
		if (got.out_byte != want.out_byte) report("out_byte", got.out_byte, want.out_byte);
		if (got.command_index != want.command_index)
			report("command_index", got.command_index, want.command_index);
		if (got.form != want.form) report("form", got.form, want.form);
		if (got.error_code != want.error_code)
			report("error_code", got.error_code, want.error_code);
		if (got.args_offset != want.args_offset)
			report("args_offset", got.args_offset, want.args_offset);
		if (got.line_length != want.line_length)
			report("line_length", got.line_length, want.line_length);
		if (got.last != want.last) report("last", got.last, want.last);
	endtask
endclass

module tb_at_command_line_parser_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int SETTLE = 2000;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_stall;
	in_t        in_data = '0;
	logic       out_valid;
	logic       out_stall = 0;
	out_t       out_data;
	logic       cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	line_scoreboard sb = new();
	int send_pct = 7;
	int stall_pct = 81;
	int items = 0;
	bit [7:0] tbl_chr[32][16];
	int tbl_len[32];

	at_command_line_parser_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		#10ms;
		$display("FAIL");
		$finish;
	end

	function in_t random_request(logic [1:0] mode);
		logic [63:0] w;
		in_t r;
		w = {$urandom(), $urandom()};
		r = w[36:0];
		r.mode = mode;
		return r;
	endfunction

	task send(in_t r);
		bit counts;
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		counts = r.mode != MODE_UNUSED && !(r.mode == MODE_BYTE && sb.halted);
		sb.note_request(r);
		if (counts)
			items++;
	endtask

	task send_byte(bit [7:0] b);
		in_t r;
		r = random_request(MODE_BYTE);
		r.rx_byte = b;
		send(r);
	endtask

	task send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task write_name_char(int e, int p, bit [7:0] c);
		in_t r;
		r = random_request(MODE_NAME);
		r.entry_index = 5'(e);
		r.name_position = 4'(p);
		r.rx_byte = c;
		tbl_chr[e][p] = c;
		send(r);
	endtask

	task write_attr(int e, int len_field, bit [3:0] mask, bit [3:0] mn, bit [3:0] mx, bit ok);
		in_t r;
		r = random_request(MODE_ATTR);
		r.entry_index = 5'(e);
		r.name_length = 5'(len_field);
		r.handler_mask = mask;
		r.min_arguments = mn;
		r.max_arguments = mx;
		r.format_valid = ok;
		tbl_len[e] = (len_field > 16) ? 16 : len_field;
		send(r);
	endtask

	function bit [7:0] name_char();
		int k;
		k = $urandom_range(9);
		if (k == 0) return 8'h2B;
		if (k == 1) return 8'h5F;
		return 8'((k < 5 ? 8'h41 : 8'h61) + $urandom_range(25));
	endfunction

	task set_reg(logic [2:0] idx, logic [7:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.write_reg(idx, v);
		@(posedge clk);
	endtask

	task settle();
		in_valid <= 0;
		while (sb.expected.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task configure(bit echo, logic [7:0] m1, logic [7:0] m2, logic [1:0] mlen, logic [5:0] cnt);
		settle();
		set_reg(CFG_ECHO, {7'd0, echo});
		set_reg(CFG_MARK1, m1);
		set_reg(CFG_MARK2, m2);
		set_reg(CFG_MARKLEN, {6'd0, mlen});
		set_reg(CFG_COUNT, {2'd0, cnt});
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// shape: 0 test, 1 query, 2 setup with args, 3 digit setup, 4 exec, 5 bad form
	task send_command(int e, int shape, bit edit);
		bit [7:0] q[$];
		bit [7:0] c;
		int n;
		for (int i = 0; i < tbl_len[e]; i++) begin
			c = tbl_chr[e][i];
			if ($urandom_range(1) && ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)))
				c ^= 8'h20;
			q.push_back(c);
		end
		case (shape)
			0: begin q.push_back(CH_EQ); q.push_back(CH_QUEST); end
			1: q.push_back(CH_QUEST);
			2: begin
				q.push_back(CH_EQ);
				n = $urandom_range(5);
				for (int a = 0; a < n; a++) begin
					if (a > 0) q.push_back(CH_COMMA);
					repeat ($urandom_range(1, 3)) q.push_back(8'(CH_0 + $urandom_range(9)));
				end
			end
			3: q.push_back(8'(CH_0 + $urandom_range(9)));
			4: ;
			default: begin q.push_back(CH_QUEST); q.push_back(name_char()); end
		endcase
		if (edit) begin
			n = $urandom_range(q.size());
			q.insert(n, ($urandom_range(1) ? CH_BS : CH_DEL));
			q.insert(n, name_char());
		end
		q.push_back(CH_CR);
		if (sb.mark_len == 2) begin
			if (sb.mark_a != CH_CR) q.push_back(sb.mark_a);
			q.push_back(sb.mark_b);
		end else if (sb.mark_a != CH_CR)
			q.push_back(sb.mark_a);
		foreach (q[i])
			send_byte(q[i]);
	endtask

	task random_traffic(int target);
		int k, e, p;
		bit [7:0] b;
		while (items < target) begin
			k = $urandom_range(99);
			e = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(11);
			if (k < 60)
				send_command(e, $urandom_range(4), $urandom_range(5) == 0);
			else if (k < 70)
				send_command(e, $urandom_range(5), 1);
			else if (k < 80) begin
				repeat ($urandom_range(1, 6)) begin
					b = 8'($urandom_range(255));
					if (b == CH_ESC) b = 8'h00;
					send_byte(b);
				end
			end else if (k < 86)
				write_attr(e, tbl_len[e], 4'($urandom_range(15)), 4'($urandom_range(15)),
					4'($urandom_range(15)), $urandom_range(3) != 0);
			else if (k < 92) begin
				if (tbl_len[e] > 0) begin
					p = $urandom_range(tbl_len[e] - 1);
					write_name_char(e, p,
						$urandom_range(7) == 0 ? 8'($urandom_range(255)) : name_char());
				end
			end else if (k < 95)
				send(random_request(MODE_UNUSED));
			else
				send_command($urandom_range(12, 30), $urandom_range(4), 0);
		end
	endtask

	initial begin
		int len;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// table: short names, empty names, and one full-width name
		for (int e = 0; e < 32; e++) begin
			len = (e < 12) ? $urandom_range(1, 6) : (e == 31 ? 16 : 0);
			for (int p = 0; p < len; p++)
				write_name_char(e, p, name_char());
			write_attr(e, (e == 31) ? 31 : len,
				$urandom_range(3) ? 4'hF : 4'($urandom_range(15)),
				4'($urandom_range(2)), 4'($urandom_range(2, 6)), $urandom_range(5) != 0);
		end
		configure(1, CH_CR, CH_LF, 2, 32);

		// backspace on empty line, every form, editing, lone LF, bad request
		send_byte(CH_BS);
		for (int s = 0; s < 6; s++)
			send_command(0, s, 0);
		send_command(12, 1, 0);
		send_command(31, 4, 1);
		send_byte(CH_LF);
		send_text("x\x7f");
		send_command(1, 2, 0);
		send(random_request(MODE_UNUSED));
		random_traffic(items + 40);

		send_pct = 81;
		stall_pct = 7;
		configure(0, CH_LF, CH_0, 1, 20);
		send_text("ab+c\n");
		repeat (20) send_byte(8'(8'h61 + $urandom_range(25)));
		send_byte(CH_LF);
		random_traffic(items + 30);

		send_pct = 0;
		stall_pct = 0;
		configure(1, 8'hFF, 8'h00, 2, 32);
		random_traffic(items + 30);

		configure(0, CH_CR, 8'hFF, 1, 0);
		send_command(0, 4, 0);
		send_command(3, 2, 0);
		send_byte(CH_ESC);
		send_command(0, 4, 0);
		write_attr(5, tbl_len[5], 4'hF, 4'd0, 4'd15, 1);

		settle();
		$display("covered %0d requests and %0d results over four register settings,",
			items, sb.checked);
		$display("with echo on and off, one and two byte line ends, table reloads and stop");
		if (sb.mismatches == 0 && sb.expected.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
